@@ rtl/core/led_column_hue_pattern_generator_defines.svh @@
// Assertion macros shared by the LED column hue pattern generator RTL.
// Used by files that carry concurrent checks; expects clk and arst_n in scope.
`ifndef LED_COLUMN_HUE_PATTERN_GENERATOR_DEFINES_SVH
`define LED_COLUMN_HUE_PATTERN_GENERATOR_DEFINES_SVH

// Check clocked on clk, switched off while arst_n is low.
`define LCHPG_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check clocked on clk that also holds through reset.
`define LCHPG_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/lchpg_pkg.sv @@
// Types and fixed constants of the LED column hue pattern generator.
// No dependencies; imported by lchpg_color and the top level.
package lchpg_pkg;

	localparam int CH_W  = 2;
	localparam int LED_W = 4;
	localparam int HUE_W = 16;

	localparam logic [HUE_W-1:0] HUE_STEP = 16'd72;
	localparam logic [7:0] LEVEL_FULL = 8'hFF;
	localparam logic [7:0] LEVEL_DIM  = 8'h01;

	typedef enum logic [1:0] {
		MODE_WHEEL = 2'd0,
		MODE_PICK  = 2'd1,
		MODE_MARK  = 2'd2,
		MODE_OFF   = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] hue_hi;
		logic       odd_ch;
		logic       end_led;
	} pix_ctrl_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

endpackage

@@ rtl/core/lchpg_color.sv @@
// Pixel color lookup: hue wheel, three-color pick and marker pattern.
// Pure combinational; depends on lchpg_pkg.
module lchpg_color (
	input  lchpg_pkg::pix_ctrl_t ctrl,
	output lchpg_pkg::rgb_t      rgb
);
	import lchpg_pkg::*;

	logic [10:0] a6;
	logic [9:0]  a3;
	logic [7:0]  f;
	logic [7:0]  nf;
	logic [7:0]  mark_lvl;

	assign a6 = 11'(ctrl.hue_hi) * 11'd6;
	assign a3 = 10'(ctrl.hue_hi) * 10'd3;
	assign f  = a6[7:0];
	assign nf = ~a6[7:0];
	assign mark_lvl = ctrl.end_led ? LEVEL_FULL : LEVEL_DIM;

	always_comb begin
		rgb = '0;
		case (ctrl.mode)
			MODE_WHEEL: begin
				case (a6[10:8])
					3'd0: begin rgb.red = LEVEL_FULL; rgb.green = f; end
					3'd1: begin rgb.green = LEVEL_FULL; rgb.red = nf; end
					3'd2: begin rgb.green = LEVEL_FULL; rgb.blue = f; end
					3'd3: begin rgb.blue = LEVEL_FULL; rgb.green = nf; end
					3'd4: begin rgb.blue = LEVEL_FULL; rgb.red = f; end
					3'd5: begin rgb.red = LEVEL_FULL; rgb.blue = nf; end
					default: rgb = '0;
				endcase
			end
			MODE_PICK: begin
				case (a3[9:8])
					2'd0: rgb.red = LEVEL_FULL;
					2'd1: rgb.green = LEVEL_FULL;
					2'd2: rgb.blue = LEVEL_FULL;
					default: rgb = '0;
				endcase
			end
			MODE_MARK: begin
				if (ctrl.odd_ch) begin
					rgb.green = mark_lvl;
				end else begin
					rgb.red = mark_lvl;
				end
			end
			default: rgb = '0;
		endcase
	end

endmodule

@@ rtl/core/led_column_hue_pattern_generator.sv @@
// A column word passes stage 1, stage 2, the pixel generator and the output register,
// each of which can stall. The pixel generator emits one pixel per cycle unless the output
// stalls, CHANNELS*LEDS_PER_STRIP per column (32 by default); the next waits in stages 1-2.
// Reset: arst_n clears all valid flags, counters and pattern_mode (hue wheel) at once.
// Depends on lchpg_pkg, lchpg_color and the project assertion macros.
`include "led_column_hue_pattern_generator_defines.svh"

module led_column_hue_pattern_generator #(
	parameter int COLUMNS        = 256,
	parameter int LEDS_PER_STRIP = 16,
	parameter int CHANNELS       = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: pattern_mode [1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data,
	// column_index [11:0], zero fill [15:12]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,
	// channel_number [1:0], led_number [5:2], red_level [13:6],
	// green_level [21:14], blue_level [29:22], zero fill [31:30]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic        m_tlast
);
	import lchpg_pkg::*;

	// base = col*0xFFFF/COLUMNS via reciprocal: exact for any 28-bit numerator
	localparam int NUM_W   = 28;
	localparam int SHIFT   = NUM_W + $clog2(COLUMNS);
	localparam int RECIP_W = NUM_W + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << SHIFT) + 64'(COLUMNS) - 64'd1) / 64'(COLUMNS));
	localparam int PROD_W  = NUM_W + RECIP_W;

	localparam logic [HUE_W-1:0] PH1 = HUE_W'(65536 / CHANNELS);
	localparam logic [HUE_W-1:0] PH2 = HUE_W'((2 * 65536) / CHANNELS);
	localparam logic [HUE_W-1:0] PH3 = HUE_W'((3 * 65536) / CHANNELS);

	localparam logic [CH_W-1:0]  CH_LAST  = CH_W'(CHANNELS - 1);
	localparam logic [LED_W-1:0] LED_LAST = LED_W'(LEDS_PER_STRIP - 1);

	function automatic logic [HUE_W-1:0] phase_of(input logic [CH_W-1:0] ch);
		logic [HUE_W-1:0] ph;
		case (ch)
			2'd1: ph = PH1;
			2'd2: ph = PH2;
			2'd3: ph = PH3;
			default: ph = '0;
		endcase
		return ph;
	endfunction

	mode_t mode_q;

	logic              s1_valid_q;
	logic [NUM_W-1:0]  num_s1;
	logic              s2_valid_q;
	logic [PROD_W-1:0] prod_s2;

	logic              gen_valid_q;
	logic [HUE_W-1:0]  base_q;
	logic [HUE_W-1:0]  hue_q;
	logic [CH_W-1:0]   ch_q;
	logic [LED_W-1:0]  led_q;

	logic              out_valid_q;
	logic [CH_W-1:0]   out_ch_q;
	logic [LED_W-1:0]  out_led_q;
	rgb_t              out_rgb_q;
	logic              out_last_q;

	logic              gen_adv;
	logic              gen_last;
	logic              gen_take;
	logic              s2_en;
	logic [HUE_W-1:0]  base_s2;
	logic [CH_W-1:0]   ch_next;
	pix_ctrl_t         pix_ctrl;
	rgb_t              pix_rgb;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_WHEEL;
		end else if (cfg_valid) begin
			mode_q <= mode_t'(cfg_data);
		end
	end

	// pipeline flow control
	assign gen_adv  = gen_valid_q && (!out_valid_q || m_tready);
	assign gen_last = (ch_q == CH_LAST) && (led_q == LED_LAST);
	assign gen_take = s2_valid_q && (!gen_valid_q || (gen_adv && gen_last));
	assign s2_en    = !s2_valid_q || gen_take;
	assign s_tready = !s1_valid_q || s2_en;
	assign base_s2  = prod_s2[SHIFT +: HUE_W];
	assign ch_next  = ch_q + 1'b1;

	// stage 1: col*0xFFFF as (col<<16) - col
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			num_s1 <= ({s_tdata[11:0], 16'd0}) - NUM_W'(s_tdata[11:0]);
		end
	end

	// stage 2: reciprocal multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_en) begin
			s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_en && s1_valid_q) begin
			prod_s2 <= PROD_W'(num_s1) * PROD_W'(RECIP);
		end
	end

	// pixel generator: walk LEDs within a channel, then channels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_valid_q <= 1'b0;
			ch_q        <= '0;
			led_q       <= '0;
		end else if (gen_take) begin
			gen_valid_q <= 1'b1;
			ch_q        <= '0;
			led_q       <= '0;
		end else if (gen_adv) begin
			if (gen_last) begin
				gen_valid_q <= 1'b0;
			end else if (led_q == LED_LAST) begin
				ch_q  <= ch_next;
				led_q <= '0;
			end else begin
				led_q <= led_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (gen_take) begin
			base_q <= base_s2;
			hue_q  <= base_s2;
		end else if (gen_adv && !gen_last) begin
			if (led_q == LED_LAST) begin
				hue_q <= base_q + phase_of(ch_next);
			end else begin
				hue_q <= hue_q + HUE_STEP;
			end
		end
	end

	assign pix_ctrl.mode    = mode_q;
	assign pix_ctrl.hue_hi  = hue_q[HUE_W-1 -: 8];
	assign pix_ctrl.odd_ch  = ch_q[0];
	assign pix_ctrl.end_led = (led_q == '0) || (led_q == LED_LAST);

	lchpg_color u_color (
		.ctrl (pix_ctrl),
		.rgb  (pix_rgb)
	);

	// output register: hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= gen_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (gen_adv) begin
			out_ch_q   <= ch_q;
			out_led_q  <= led_q;
			out_rgb_q  <= pix_rgb;
			out_last_q <= gen_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_rgb_q.blue, out_rgb_q.green, out_rgb_q.red,
		out_led_q, out_ch_q};
	assign m_tlast  = out_last_q;

	`LCHPG_ASSERT(a_gen_range, gen_valid_q |-> (led_q <= LED_LAST) && (ch_q <= CH_LAST), "generator counters out of range")
	`LCHPG_ASSERT(a_led_step, (gen_adv && !gen_take && (led_q != LED_LAST)) |=> (led_q == $past(led_q) + 1'b1), "LED counter skipped")
	`LCHPG_ASSERT(a_run_cont, (gen_adv && !gen_last) |=> gen_valid_q, "column run dropped before its last pixel")
	`LCHPG_ASSERT(a_last_pos, (m_tvalid && m_tlast) |-> (out_led_q == LED_LAST) && (out_ch_q == CH_LAST), "last flag on wrong pixel")
	`LCHPG_ASSERT_ALWAYS(a_rst_idle, !arst_n |=> !m_tvalid, "output valid during reset")

endmodule
